@@ rtl/core/ublsu_pkg.sv @@
`default_nettype none

package ublsu_pkg;

    // Fixed widths of the request and result fields.
    localparam int ADDR_W     = 16;
    localparam int WA_W       = ADDR_W - 2;  // word part of a byte address
    localparam int DATA_W     = 32;
    localparam int LOAD_LOW_W = 33;
    localparam int LANES      = 4;           // bytes per memory word
    localparam int SPAN_WORDS = 3;           // most words one access touches

    typedef enum logic [3:0] {
        ACT_LBS = 4'd0,
        ACT_LBU = 4'd1,
        ACT_LHS = 4'd2,
        ACT_LHU = 4'd3,
        ACT_LW  = 4'd4,
        ACT_LD  = 4'd5,
        ACT_SB  = 4'd6,
        ACT_SH  = 4'd7,
        ACT_SW  = 4'd8,
        ACT_SD  = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ACCESS,
        ST_HOLD
    } lsu_state_t;

    // Number of bytes an action moves; zero for codes that mean nothing.
    function automatic logic [3:0] access_bytes(input logic [3:0] act);
        logic [3:0] n;
        case (act) inside
            ACT_LBS, ACT_LBU, ACT_SB: n = 4'd1;
            ACT_LHS, ACT_LHU, ACT_SH: n = 4'd2;
            ACT_LW, ACT_SW:           n = 4'd4;
            ACT_LD, ACT_SD:           n = 4'd8;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_store(input logic [3:0] act);
        logic s;
        case (act) inside
            ACT_SB, ACT_SH, ACT_SW, ACT_SD: s = 1'b1;
            default:                        s = 1'b0;
        endcase
        return s;
    endfunction

    // Byte enables of an access that starts in lane zero.
    function automatic logic [7:0] first_lanes(input logic [3:0] n);
        logic [7:0] m;
        case (n)
            4'd1:    m = 8'h01;
            4'd2:    m = 8'h03;
            4'd4:    m = 8'h0F;
            4'd8:    m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Widens four byte enables into a bit mask for one word.
    function automatic logic [DATA_W-1:0] lane_bits(input logic [LANES-1:0] be);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < LANES; i++) begin
            m[8*i +: 8] = {8{be[i]}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ublsu_ram.sv @@
`default_nettype none

// Single-port-write, single-port-read memory with a registered read.
// A read and a write of the same entry in one cycle return the old word.
module ublsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/unaligned_byte_load_store_unit_top.sv @@
// Byte-addressed load/store unit in front of a scratch memory of MEM_WORDS
// 32-bit words with little-endian byte lanes. A request carries an action
// in s_axis_tuser (lbs, lbu, lhs, lhu, lw, ld, sb, sh, sw, sd) and a byte
// address of any alignment; accesses may straddle word boundaries and wrap
// at the end of the memory. Loads return one result on the master side,
// stores and unknown actions return nothing. A request is taken only while
// the unit is idle; the unit then reads each memory word that it touches
// (one to three) in turn through the single read port of the memory. When
// MEM_WORDS is neither a power of two nor at least 16384, the word index is
// first reduced modulo MEM_WORDS by a reciprocal multiplication that
// registers the quotient and then the remainder. Stores merge their bytes by
// read-modify-write; a word written in one cycle and read in the same cycle
// is forwarded. A finished load waits in the output register, and the unit
// takes the next request while it waits. A word must be written before it
// is read; the memory contents are undefined after reset.

`default_nettype none

module unaligned_byte_load_store_unit_top
    import ublsu_pkg::*;
#(
    parameter int MEM_WORDS = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] byte_address, [47:16] store_low, [79:48] store_high
    input  wire logic [79:0] s_axis_tdata,
    // [3:0] action
    input  wire logic [3:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [32:0] load_low (two's complement), [64:33] load_high, [71:65] zero
    output logic      [71:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MEM_WORDS);
    // The word index needs a true modulo only when the memory is smaller than
    // the address range and its size is not a power of two.
    localparam bit NEED_MOD = (MEM_WORDS < (2 ** WA_W)) &&
                              ((MEM_WORDS & (MEM_WORDS - 1)) != 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);
    // Scaled reciprocal of the memory size; one multiply and a shift give the
    // exact quotient of any word address.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << (WA_W + IDX_W)) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [WA_W:0]    RECIP    = (WA_W + 1)'(RECIP_FULL);
    localparam logic [WA_W-1:0]  MOD_WORD = WA_W'(MEM_WORDS);
    localparam logic [3:0]       RED_LAST = 4'd1;

    // Request fields.
    logic [3:0]        act_in;
    logic [ADDR_W-1:0] addr_in;
    logic [DATA_W-1:0] lo_in;
    logic [DATA_W-1:0] hi_in;
    logic              in_acc;

    assign act_in  = s_axis_tuser;
    assign addr_in = s_axis_tdata[15:0];
    assign lo_in   = s_axis_tdata[47:16];
    assign hi_in   = s_axis_tdata[79:48];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Decode of a new request.
    logic [3:0]               nbytes_in;
    logic [3:0]               span_in;
    logic [1:0]               nw_in;
    logic [11:0]              bmask_in;
    logic [95:0]              sdata_in;
    logic [WA_W+IDX_W-1:0]    base_ext;
    logic [IDX_W-1:0]         base_in;

    assign nbytes_in = access_bytes(act_in);
    assign span_in   = {2'b00, addr_in[1:0]} + nbytes_in + 4'd3;
    assign nw_in     = span_in[3:2];
    assign bmask_in  = {4'b0000, first_lanes(nbytes_in)} << addr_in[1:0];
    assign sdata_in  = {32'b0, hi_in, lo_in} << {addr_in[1:0], 3'b000};
    assign base_ext  = {{IDX_W{1'b0}}, addr_in[ADDR_W-1:2]};
    assign base_in   = base_ext[IDX_W-1:0];

    // Control state.
    lsu_state_t state_reg, state_next;
    logic [1:0]  rd_k_reg;
    logic [1:0]  wb_k_reg;
    logic        dv_reg;
    logic        fwd_reg;
    logic [3:0]  red_cnt_reg;
    logic        m_valid_reg;

    // Request payload and datapath.
    logic [3:0]        act_reg;
    logic [1:0]        lane_reg;
    logic [1:0]        nw_reg;
    logic              store_reg;
    logic [11:0]       bmask_reg;
    logic [95:0]       sdata_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  wb_idx_reg;
    logic [WA_W-1:0]   red_sh_reg;
    logic [WA_W-1:0]   red_q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [DATA_W-1:0] buf_reg [SPAN_WORDS];
    logic [DATA_W-1:0] buf_next [SPAN_WORDS];
    logic [71:0]       m_data_reg;

    // Memory.
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] word_in;
    logic [DATA_W-1:0] word_merged;
    logic [DATA_W-1:0] wr_bits;
    logic [DATA_W-1:0] wr_data;

    ublsu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wb_idx_reg),
        .wdata (word_merged),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Word arriving from the memory, or the one merged just before it.
    assign word_in = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        case (wb_k_reg)
            2'd0:    wr_bits = lane_bits(bmask_reg[3:0]);
            2'd1:    wr_bits = lane_bits(bmask_reg[7:4]);
            default: wr_bits = lane_bits(bmask_reg[11:8]);
        endcase
        case (wb_k_reg)
            2'd0:    wr_data = sdata_reg[31:0];
            2'd1:    wr_data = sdata_reg[63:32];
            default: wr_data = sdata_reg[95:64];
        endcase
    end

    assign word_merged = (word_in & ~wr_bits) | (wr_data & wr_bits);

    // Index of the next word, wrapping at the end of the memory.
    logic [IDX_W-1:0] idx_inc;
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Modulo reduction of the word address: the quotient is registered, and the
    // remainder is then found by subtracting the quotient times the memory size.
    logic [2*WA_W:0] red_prod;
    logic [2*WA_W:0] red_quo;
    logic [WA_W-1:0] red_qm;
    logic [WA_W-1:0] red_rem;
    assign red_prod = {{(WA_W + 1){1'b0}}, red_sh_reg} * {{WA_W{1'b0}}, RECIP};
    assign red_quo  = red_prod >> (WA_W + IDX_W);
    assign red_qm   = red_q_reg * MOD_WORD;
    assign red_rem  = red_sh_reg - red_qm;

    // Control decode.
    logic issue;
    logic last_word;
    logic seq_done;
    logic out_free;
    logic out_load;
    logic in_valid_act;

    assign in_valid_act = (nbytes_in != 4'd0);
    assign last_word    = (wb_k_reg == nw_reg - 2'd1);
    assign out_free     = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        seq_done      = 1'b0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_REDUCE:
            begin
            end
            ST_ACCESS:
            begin
                issue    = (rd_k_reg != nw_reg);
                seq_done = dv_reg && last_word;
                ram_we   = dv_reg && store_reg;
                out_load = seq_done && !store_reg && out_free;
            end
            ST_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign ram_re = issue;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_valid_act)
                begin
                    state_next = NEED_MOD ? ST_REDUCE : ST_ACCESS;
                end
            end
            ST_REDUCE:
            begin
                if (red_cnt_reg == RED_LAST)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (seq_done)
                begin
                    state_next = (store_reg || out_free) ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load buffer: the words of the access in ascending order.
    always_comb
    begin
        for (int i = 0; i < SPAN_WORDS; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (state_reg == ST_ACCESS && dv_reg)
        begin
            case (wb_k_reg)
                2'd0:    buf_next[0] = word_in;
                2'd1:    buf_next[1] = word_in;
                default: buf_next[2] = word_in;
            endcase
        end
    end

    // Load result, aligned from the buffered words.
    logic [95:0]           ld_all;
    logic [63:0]           ld_val;
    logic [LOAD_LOW_W-1:0] load_low;
    logic [DATA_W-1:0]     load_high;

    assign ld_all = {buf_next[2], buf_next[1], buf_next[0]} >> {lane_reg, 3'b000};
    assign ld_val = ld_all[63:0];

    always_comb
    begin
        load_high = '0;
        case (act_reg)
            ACT_LBS: load_low = {{25{ld_val[7]}}, ld_val[7:0]};
            ACT_LBU: load_low = {25'b0, ld_val[7:0]};
            ACT_LHS: load_low = {{17{ld_val[15]}}, ld_val[15:0]};
            ACT_LHU: load_low = {17'b0, ld_val[15:0]};
            ACT_LD:
            begin
                load_low  = {1'b0, ld_val[31:0]};
                load_high = ld_val[63:32];
            end
            default: load_low = {1'b0, ld_val[31:0]};
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_k_reg    <= '0;
            dv_reg      <= 1'b0;
            fwd_reg     <= 1'b0;
            red_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                rd_k_reg    <= '0;
                dv_reg      <= 1'b0;
                fwd_reg     <= 1'b0;
                red_cnt_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_REDUCE)
                begin
                    red_cnt_reg <= red_cnt_reg + 4'd1;
                end
                if (issue)
                begin
                    rd_k_reg <= rd_k_reg + 2'd1;
                end
                dv_reg  <= issue;
                fwd_reg <= issue && ram_we && (idx_reg == wb_idx_reg);
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg    <= act_in;
            lane_reg   <= addr_in[1:0];
            nw_reg     <= nw_in;
            store_reg  <= is_store(act_in);
            bmask_reg  <= bmask_in;
            sdata_reg  <= sdata_in;
            red_sh_reg <= addr_in[ADDR_W-1:2];
            idx_reg    <= NEED_MOD ? '0 : base_in;
        end
        else if (state_reg == ST_REDUCE)
        begin
            if (red_cnt_reg == RED_LAST)
            begin
                idx_reg <= IDX_W'(red_rem);
            end
            else
            begin
                red_q_reg <= red_quo[WA_W-1:0];
            end
        end
        else if (issue)
        begin
            idx_reg    <= idx_inc;
            wb_idx_reg <= idx_reg;
            wb_k_reg   <= rd_k_reg;
        end
        fwd_data_reg <= word_merged;
        for (int i = 0; i < SPAN_WORDS; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        if (out_load)
        begin
            m_data_reg <= {7'b0, load_high, load_low};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Memory writes happen only while an access is being worked on.
    a_write_in_access: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_ACCESS)
        else $error("memory written outside an access");

    // The read counter never runs past the words of the access.
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACCESS |-> rd_k_reg <= nw_reg)
        else $error("read counter past the end of the access");

    // A result appears only at the end of a load.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(state_reg == ST_ACCESS || state_reg == ST_HOLD))
        else $error("result without a finished load");

    // The unit waits with a finished load only while the output is full.
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> m_axis_tvalid)
        else $error("holding a load with an empty output register");

endmodule

`default_nettype wire

@@ tb/unaligned_byte_load_store_unit_top_tb.sv @@
`default_nettype none

module unaligned_byte_load_store_unit_top_tb;

    import ublsu_pkg::*;

    // Action codes outside the defined set; the unit must drop these silently.
    localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

    localparam int MEM_BYTES      = 65536;
    localparam int RANDOM_COUNT   = 900;
    localparam int DRAIN_CYCLES   = 20;

    // Shadow copy of the scratch memory. Every accepted request updates it in
    // the order the unit took them, and every load leaves its expected data
    // in a queue that the result monitor drains in order.
    class lsu_shadow_memory;
        typedef struct {
            logic [32:0] low;
            logic [31:0] high;
        } load_data_t;

        bit [31:0]  word_mem [16384];
        bit         byte_set [MEM_BYTES];
        load_data_t pending_loads [$];
        int         errors;
        int         loads_seen;
        int         stores_seen;
        int         dropped_seen;
        int         results_checked;

        function int span_of(logic [3:0] act);
            int n;
            case (act)
                ACT_LBS, ACT_LBU, ACT_SB: n = 1;
                ACT_LHS, ACT_LHU, ACT_SH: n = 2;
                ACT_LW, ACT_SW:           n = 4;
                ACT_LD, ACT_SD:           n = 8;
                default:                  n = 0;
            endcase
            return n;
        endfunction

        function logic [7:0] get_byte(logic [15:0] a);
            return word_mem[a[15:2]][8*a[1:0] +: 8];
        endfunction

        function void put_byte(logic [15:0] a, logic [7:0] v);
            word_mem[a[15:2]][8*a[1:0] +: 8] = v;
            byte_set[a] = 1'b1;
        endfunction

        // True when every byte a load would touch has been stored before.
        function bit can_load(logic [3:0] act, logic [15:0] a);
            bit ok;
            ok = 1'b1;
            for (int i = 0; i < span_of(act); i++) begin
                if (!byte_set[16'(a + 16'(i))])
                    ok = 1'b0;
            end
            return ok;
        endfunction

        function void note_request(logic [3:0] act, logic [15:0] a,
                                   logic [31:0] lo, logic [31:0] hi);
            logic [31:0] gathered;
            logic [31:0] upper;
            load_data_t  want;
            gathered = '0;
            upper    = '0;
            case (act)
                ACT_SB, ACT_SH, ACT_SW:
                begin
                    for (int i = 0; i < span_of(act); i++)
                        put_byte(16'(a + 16'(i)), lo[8*i +: 8]);
                    stores_seen++;
                end
                ACT_SD:
                begin
                    // The upper word goes in first, then the word at the address.
                    for (int i = 0; i < 4; i++)
                        put_byte(16'(a + 16'd4 + 16'(i)), hi[8*i +: 8]);
                    for (int i = 0; i < 4; i++)
                        put_byte(16'(a + 16'(i)), lo[8*i +: 8]);
                    stores_seen++;
                end
                ACT_LBS, ACT_LBU, ACT_LHS, ACT_LHU, ACT_LW, ACT_LD:
                begin
                    for (int i = 0; i < 4 && i < span_of(act); i++)
                        gathered[8*i +: 8] = get_byte(16'(a + 16'(i)));
                    if (act == ACT_LD) begin
                        for (int i = 0; i < 4; i++)
                            upper[8*i +: 8] = get_byte(16'(a + 16'd4 + 16'(i)));
                    end
                    case (act)
                        ACT_LBS: want.low = {{25{gathered[7]}}, gathered[7:0]};
                        ACT_LBU: want.low = {25'd0, gathered[7:0]};
                        ACT_LHS: want.low = {{17{gathered[15]}}, gathered[15:0]};
                        ACT_LHU: want.low = {17'd0, gathered[15:0]};
                        default: want.low = {1'b0, gathered};
                    endcase
                    want.high = upper;
                    pending_loads.push_back(want);
                    loads_seen++;
                end
                default:
                    dropped_seen++;
            endcase
        endfunction

        function void check_result(logic [71:0] beat);
            load_data_t want;
            if (pending_loads.size() == 0) begin
                $error("result 0x%h arrived with no load outstanding", beat);
                errors++;
                return;
            end
            want = pending_loads.pop_front();
            results_checked++;
            if (beat[32:0] !== want.low) begin
                $error("load_low: expected 0x%h, got 0x%h", want.low, beat[32:0]);
                errors++;
            end
            if (beat[64:33] !== want.high) begin
                $error("load_high: expected 0x%h, got 0x%h", want.high, beat[64:33]);
                errors++;
            end
            if (beat[71:65] !== 7'd0) begin
                $error("pad: expected 0x%h, got 0x%h", 7'd0, beat[71:65]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    // Percent chance per cycle that the sender holds back or the receiver
    // stalls. The main sequence moves these between phases.
    int send_idle_pct = 14;
    int recv_idle_pct = 45;

    lsu_shadow_memory lsu_shadow;

    unaligned_byte_load_store_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // The result side stalls at random. All sampling happens right after the
    // rising edge, before any nonblocking update of that edge lands, so the
    // values seen are the ones the flops captured.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result that the unit hands over is compared with the oldest load
    // still waiting in the shadow memory's queue.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lsu_shadow.check_result(m_axis_tdata);
    end

    // Presents one request, possibly after a random idle stretch, and holds it
    // until the unit takes it. The valid line is only ever given one new value
    // per edge, so back-to-back requests keep it high without a glitch.
    task automatic send_request(input logic [3:0] act, input logic [15:0] a,
                                input logic [31:0] lo, input logic [31:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {hi, lo, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lsu_shadow.note_request(act, a, lo, hi);
    endtask

    // Hard stop in case the unit hangs on a handshake.
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int          made;
        int          pick;
        logic [3:0]  act;
        logic [15:0] addr;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [15:0] recent_stores [$];

        lsu_shadow = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A word with both sign patterns at address zero covers
        // signed and unsigned byte loads; the double store just below the top
        // of memory wraps into word zero and touches three words at once.
        send_request(ACT_SW, 16'h0000, 32'h80FF_7F01, 32'h0000_0000);
        send_request(ACT_LBS, 16'h0000, '0, '0);
        send_request(ACT_LBS, 16'h0003, '0, '0);
        send_request(ACT_LBU, 16'h0003, '0, '0);
        send_request(ACT_SW, 16'hFFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_SD, 16'hFFFE, 32'hDEAD_BEEF, 32'h8001_7FFE);
        send_request(ACT_LD, 16'hFFFE, '0, '0);
        send_request(ACT_LHS, 16'hFFFF, '0, '0);
        send_request(ACT_LHU, 16'hFFFF, '0, '0);
        send_request(ACT_LW, 16'hFFFD, '0, '0);
        send_request(ACT_SB, 16'h0001, 32'h0000_00FF, 32'hFFFF_FFFF);
        send_request(ACT_LBU, 16'h0001, '0, '0);
        // A half store straddling words zero and one, read back signed.
        send_request(ACT_SH, 16'h0003, 32'hFFFF_8000, '0);
        send_request(ACT_LHS, 16'h0003, '0, '0);
        send_request(ACT_SD, 16'h1003, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_LD, 16'h1003, '0, '0);
        send_request(ACT_LW, 16'h1005, '0, '0);
        send_request(ACT_SW, 16'h8000, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_LW, 16'h8000, '0, '0);
        // Undefined action codes must leave memory alone and return nothing.
        send_request(ACT_UNUSED_LO, 16'h0000, 32'h1234_5678, '0);
        send_request(ACT_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_LW, 16'h0000, '0, '0);

        // Random part. Most addresses land in a window near the bottom or top
        // of memory, or reuse a recent store address, so loads find written
        // data; a load of bytes never stored turns into a store of that size.
        made = 0;
        while (made < RANDOM_COUNT) begin
            if (made < RANDOM_COUNT / 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 45;
            end else if (made < 2 * RANDOM_COUNT / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(99);
            if (pick < 35)
                addr = 16'($urandom_range(0, 255));
            else if (pick < 65)
                addr = 16'($urandom_range(16'hFF00, 16'hFFFF));
            else if (pick < 85 && recent_stores.size() > 0)
                addr = recent_stores[$urandom_range(recent_stores.size() - 1)];
            else
                addr = 16'($urandom);

            if ($urandom_range(99) < 4)
                act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            else
                act = 4'($urandom_range(ACT_LBS, ACT_SD));

            if (!is_store(act) && !lsu_shadow.can_load(act, addr)) begin
                case (act)
                    ACT_LBS, ACT_LBU: act = ACT_SB;
                    ACT_LHS, ACT_LHU: act = ACT_SH;
                    ACT_LW:           act = ACT_SW;
                    default:          act = ACT_SD;
                endcase
            end

            pick = $urandom_range(99);
            lo = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
            pick = $urandom_range(99);
            hi = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;

            if (act >= ACT_SB && act <= ACT_SD) begin
                recent_stores.push_back(addr);
                if (recent_stores.size() > 64)
                    void'(recent_stores.pop_front());
            end

            send_request(act, addr, lo, hi);
            if (act <= ACT_SD)
                made++;
        end
        s_axis_tvalid <= 1'b0;

        // Let every outstanding load come back, then give a trailing store
        // time to finish its read-modify-write.
        while (lsu_shadow.pending_loads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d loads, %0d stores and %0d undefined actions; %0d results compared.",
                 lsu_shadow.loads_seen, lsu_shadow.stores_seen,
                 lsu_shadow.dropped_seen, lsu_shadow.results_checked);
        $display("Addresses spanned both ends of memory with wraparound, under three stall mixes.");
        if (lsu_shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
